// File: src/ubd_pkg.sv
package ubd_pkg;

  // field widths
  localparam int unsigned BaudW = 23;
  localparam int unsigned FreqW = 27;
  localparam int unsigned PreW  = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned DIVISOR_BITS = 16;

  // divider datapath: covers clk + 8*baud and clk + div*p/2
  localparam int unsigned DivW = FreqW + 1;
  localparam int unsigned DIV_STAGES = DivW;

  // scaled divisor width, prescaler up to 4
  localparam int unsigned DpW = DIVISOR_BITS + 2;

  // candidate latency: front, divider, middle, divider, finish
  localparam int unsigned CAND_LAT = 2 * DIV_STAGES + 3;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_CLOCK_FREQ = 1'b0,
    CFG_FORCED_PRE = 1'b1
  } cfg_idx_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  localparam logic [PreW-1:0] PRE_ONE  = 3'd1;
  localparam logic [PreW-1:0] PRE_FOUR = 3'd4;
  localparam logic [PreW-1:0] PRE_AUTO = 3'd0;

  // result of one prescaler candidate
  typedef struct packed {
    logic [DIVISOR_BITS-1:0] divisor;
    logic [FreqW-1:0]        achieved;
    logic [FreqW-1:0]        error;
    status_e                 status;
  } cand_res_t;

endpackage

// File: src/ubd_ifs.sv
interface ubd_req_if;
  import ubd_pkg::*;
  logic             valid;
  logic             ready;
  logic [BaudW-1:0] desired_baud;

  modport source (output valid, output desired_baud, input ready);
  modport sink (input valid, input desired_baud, output ready);
endinterface

interface ubd_rsp_if;
  import ubd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DIVISOR_BITS-1:0] divisor;
  logic [PreW-1:0]         prescaler_used;
  logic [FreqW-1:0]        achieved_baud;
  logic [FreqW-1:0]        rate_error;
  logic [StatW-1:0]        status;

  modport source (output valid, output divisor, output prescaler_used,
                  output achieved_baud, output rate_error, output status,
                  input ready);
  modport sink (input valid, input divisor, input prescaler_used,
                input achieved_baud, input rate_error, input status,
                output ready);
endinterface

// File: src/uart_baud_divisor_calculator.sv
// UART baud divisor calculator, 16x oversampling, round-to-nearest throughout.
// Each desired baud transaction returns one result: divisor-latch value,
// prescaler (1 or 4), achieved rate, absolute error and status. The block is
// fully pipelined: a new request is taken every cycle while the output is not stalled,
// and the result's path runs through the two 28-stage bit-per-stage dividers
// that each prescaler candidate runs in series (divisor, then achieved rate).
// Both candidates run side by side; with automatic choice prescaler 4 wins only
// on a strictly smaller error. A stalled output freezes the whole pipeline.
// Configuration must only be written while no request is in flight.
module uart_baud_divisor_calculator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [ubd_pkg::FreqW-1:0]  cfg_data_i,
  ubd_req_if.sink                    req_i,
  ubd_rsp_if.source                  rsp_o
);
  import ubd_pkg::*;

  // configuration registers
  logic [FreqW-1:0] clk_freq_q;
  logic [PreW-1:0]  forced_pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_freq_q   <= FreqW'(14745600);
      forced_pre_q <= PRE_AUTO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLOCK_FREQ: clk_freq_q   <= cfg_data_i;
        CFG_FORCED_PRE: forced_pre_q <= cfg_data_i[PreW-1:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // valid bits beside the candidates
  logic [CAND_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[CAND_LAT-2:0], req_i.valid};
    end
  end

  cand_res_t res1, res4;

  ubd_cand u_cand1 (
    .clk_i      (clk_i),
    .en_i       (en),
    .is_four_i  (1'b0),
    .clk_freq_i (clk_freq_q),
    .baud_i     (req_i.desired_baud),
    .res_o      (res1)
  );

  ubd_cand u_cand4 (
    .clk_i      (clk_i),
    .en_i       (en),
    .is_four_i  (1'b1),
    .clk_freq_i (clk_freq_q),
    .baud_i     (req_i.desired_baud),
    .res_o      (res4)
  );

  // candidate choice
  logic      pick4;
  cand_res_t best;

  always_comb begin
    priority if (forced_pre_q == PRE_AUTO) begin
      pick4 = res4.error < res1.error;
    end else if (forced_pre_q == PRE_FOUR) begin
      pick4 = 1'b1;
    end else begin
      pick4 = 1'b0;
    end
    best = pick4 ? res4 : res1;
  end

  // output register
  cand_res_t       out_q;
  logic [PreW-1:0] out_pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[CAND_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q     <= best;
      out_pre_q <= pick4 ? PRE_FOUR : PRE_ONE;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.divisor        = out_q.divisor;
  assign rsp_o.prescaler_used = out_pre_q;
  assign rsp_o.achieved_baud  = out_q.achieved;
  assign rsp_o.rate_error     = out_q.error;
  assign rsp_o.status         = out_q.status;

endmodule

// File: src/ubd_div_pipe.sv
module ubd_div_pipe (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ubd_pkg::DivW-1:0] num_i,
  input  logic [ubd_pkg::DivW-1:0] den_i,
  output logic [ubd_pkg::DivW-1:0] quo_o
);
  import ubd_pkg::*;

  // one quotient bit per stage, restoring division
  logic [DivW-1:0] rem_q [DIV_STAGES];
  logic [DivW-1:0] num_q [DIV_STAGES];
  logic [DivW-1:0] den_q [DIV_STAGES];
  logic [DivW-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DivW-1:0] rem_in, num_in, den_in, quo_in;
    logic [DivW:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, num_in[DIV_STAGES-1-s]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DivW'(trial - {1'b0, den_in}) : trial[DivW-1:0];
        num_q[s] <= num_in;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[DivW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// File: src/ubd_cand.sv
module ubd_cand (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      is_four_i,
  input  logic [ubd_pkg::FreqW-1:0] clk_freq_i,
  input  logic [ubd_pkg::BaudW-1:0] baud_i,
  output ubd_pkg::cand_res_t        res_o
);
  import ubd_pkg::*;

  // front: prescaled clock plus half the denominator
  logic [FreqW-1:0] scaled;
  logic [DivW-1:0]  num1_q, den1_q;
  logic [BaudW-1:0] baud_q;

  always_comb begin
    scaled = is_four_i ? FreqW'(({1'b0, clk_freq_i} + 28'd2) >> 2) : clk_freq_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= {1'b0, scaled} + DivW'({baud_i, 3'b000});
      den1_q <= DivW'({baud_i, 4'b0000});
      baud_q <= baud_i;
    end
  end

  logic [DivW-1:0] quo1;

  ubd_div_pipe u_div1 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num1_q),
    .den_i (den1_q),
    .quo_o (quo1)
  );

  // baud travels beside the first divider
  logic [BaudW-1:0] baud_dl_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      baud_dl_q[0] <= baud_q;
      for (int i = 1; i < DIV_STAGES; i++) begin
        baud_dl_q[i] <= baud_dl_q[i-1];
      end
    end
  end

  // middle: saturate, classify, set up the achieved-rate division
  logic                    sat;
  logic [DIVISOR_BITS-1:0] div_d;
  status_e                 stat_d;
  logic [DpW-1:0]          dp;

  logic [DIVISOR_BITS-1:0] div_q;
  status_e                 stat_q;
  logic [BaudW-1:0]        baud2_q;
  logic [DivW-1:0]         num2_q, den2_q;

  always_comb begin
    sat    = quo1[DivW-1:DIVISOR_BITS] != '0;
    div_d  = sat ? {DIVISOR_BITS{1'b1}} : quo1[DIVISOR_BITS-1:0];
    stat_d = sat ? ST_OVERFLOW : ((quo1 == '0) ? ST_ZERO : ST_OK);
    dp     = is_four_i ? {div_d, 2'b00} : DpW'(div_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q   <= div_d;
      stat_q  <= stat_d;
      baud2_q <= baud_dl_q[DIV_STAGES-1];
      num2_q  <= {1'b0, clk_freq_i} + DivW'(dp >> 1);
      den2_q  <= DivW'(dp);
    end
  end

  logic [DivW-1:0] quo2;

  ubd_div_pipe u_div2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num2_q),
    .den_i (den2_q),
    .quo_o (quo2)
  );

  // sideband beside the second divider
  logic [BaudW-1:0]        baud_d2_q [DIV_STAGES];
  logic [DIVISOR_BITS-1:0] div_dl_q  [DIV_STAGES];
  status_e                 stat_dl_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      baud_d2_q[0] <= baud2_q;
      div_dl_q[0]  <= div_q;
      stat_dl_q[0] <= stat_q;
      for (int i = 1; i < DIV_STAGES; i++) begin
        baud_d2_q[i] <= baud_d2_q[i-1];
        div_dl_q[i]  <= div_dl_q[i-1];
        stat_dl_q[i] <= stat_dl_q[i-1];
      end
    end
  end

  // finish: divide by 16 with rounding, absolute error
  logic [FreqW-1:0] ach;
  logic [FreqW-1:0] baud_x;
  logic [DivW:0]    q_rnd;

  always_comb begin
    q_rnd  = {1'b0, quo2} + (DivW+1)'(8);
    ach    = (div_dl_q[DIV_STAGES-1] == '0) ? '0 : FreqW'(q_rnd >> 4);
    baud_x = FreqW'(baud_d2_q[DIV_STAGES-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.divisor  <= div_dl_q[DIV_STAGES-1];
      res_o.achieved <= ach;
      res_o.error    <= (ach >= baud_x) ? (ach - baud_x) : (baud_x - ach);
      res_o.status   <= stat_dl_q[DIV_STAGES-1];
    end
  end

endmodule

// File: test/tb_uart_baud_divisor_calculator.sv
module tb_uart_baud_divisor_calculator;
  import ubd_pkg::*;

  localparam int unsigned LATENCY = 2 * DIV_STAGES + 4;

  // one expected divisor result
  typedef struct packed {
    logic [DIVISOR_BITS-1:0] divisor;
    logic [PreW-1:0]         pre;
    logic [FreqW-1:0]        achieved;
    logic [FreqW-1:0]        err;
    status_e                 status;
  } div_res_t;

  // directed stimulus row; chk set where the result is typed in
  typedef struct {
    logic [BaudW-1:0] baud;
    bit               chk;
    div_res_t         res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [FreqW-1:0] cfg_data_i;

  ubd_req_if req ();
  ubd_rsp_if rsp ();

  uart_baud_divisor_calculator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req.sink),
    .rsp_o      (rsp.source)
  );

  // predictor copy of the configuration
  logic [FreqW-1:0] ref_clk_hz;
  logic [PreW-1:0]  ref_pre_sel;

  div_res_t expected_q[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_zero, n_ovf, n_four;
  bit rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  // evaluate one prescaler candidate
  function automatic div_res_t try_prescaler(logic [BaudW-1:0] baud, int unsigned p);
    div_res_t r;
    longint unsigned maxd, scaled, d, ach;
    maxd = (64'd1 << DIVISOR_BITS) - 1;
    scaled = rdiv(ref_clk_hz, p);
    r.status = ST_OK;
    if (baud == 0) begin
      d = maxd;
      r.status = ST_OVERFLOW;
    end else begin
      d = rdiv(scaled, 64'(baud) * 16);
      if (d > maxd) begin
        d = maxd;
        r.status = ST_OVERFLOW;
      end else if (d == 0) begin
        r.status = ST_ZERO;
      end
    end
    ach = (d == 0) ? 0 : rdiv(rdiv(ref_clk_hz, d * p), 16);
    r.divisor = d[DIVISOR_BITS-1:0];
    r.pre = p[PreW-1:0];
    r.achieved = ach[FreqW-1:0];
    r.err = (ach >= baud) ? FreqW'(ach - baud) : FreqW'(baud - ach);
    return r;
  endfunction

  function automatic div_res_t predict_divisor(logic [BaudW-1:0] baud);
    div_res_t one, four;
    if (ref_pre_sel == PRE_AUTO) begin
      one = try_prescaler(baud, 1);
      four = try_prescaler(baud, 4);
      return (four.err < one.err) ? four : one;
    end
    return try_prescaler(baud, (ref_pre_sel == PRE_FOUR) ? 4 : 1);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // register write; only used while idle
  task automatic write_reg(cfg_idx_e idx, logic [FreqW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CLOCK_FREQ) ref_clk_hz = val;
    else ref_pre_sel = val[PreW-1:0];
    @(posedge clk_i);
  endtask

  // offer one request transaction after a random gap
  task automatic send_baud(logic [BaudW-1:0] baud, bit chk, div_res_t want);
    div_res_t p;
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      req.valid <= 1'b0;
      wait_cycles(gap);
    end
    req.valid <= 1'b1;
    req.desired_baud <= baud;
    do @(posedge clk_i); while (!req.ready);
    p = predict_divisor(baud);
    if (chk && (p != want))
      $display("note: table row for baud %0d disagrees with predictor", baud);
    expected_q.push_back(chk ? want : p);
  endtask

  task automatic drain;
    int unsigned guard;
    req.valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= 100_000) begin
      $display("tb: failure");
      $finish;
    end
    wait_cycles(LATENCY + 4);
  endtask

  // random baud: mostly realistic rates, some full-range noise
  function automatic logic [BaudW-1:0] rand_baud();
    case ($urandom_range(0, 5))
      0: return BaudW'($urandom_range(0, (1 << BaudW) - 1));
      1: return BaudW'($urandom_range(0, 300));
      2: return BaudW'($urandom_range(4_000_000, 5_000_000));
      default: return BaudW'($urandom_range(300, 1_000_000));
    endcase
  endfunction

  // receiver: random gap per transaction, one long hold-off on request
  initial begin
    int unsigned gap;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        rsp.ready <= 1'b0;
        wait_cycles(LATENCY * 3);
        rx_hold = 1'b0;
      end else begin
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
          rsp.ready <= 1'b0;
          wait_cycles(gap);
        end
        rsp.ready <= 1'b1;
        do @(posedge clk_i); while (!rsp.valid && !rx_hold);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    div_res_t w;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("mismatch: result with nothing expected");
        n_errors++;
      end else begin
        w = expected_q.pop_front();
        n_results++;
        if (w.status == ST_ZERO) n_zero++;
        if (w.status == ST_OVERFLOW) n_ovf++;
        if (w.pre == PRE_FOUR) n_four++;
        if (rsp.divisor !== w.divisor) report_mismatch("divisor", rsp.divisor, w.divisor);
        if (rsp.prescaler_used !== w.pre) report_mismatch("prescaler", rsp.prescaler_used, w.pre);
        if (rsp.achieved_baud !== w.achieved)
          report_mismatch("achieved", rsp.achieved_baud, w.achieved);
        if (rsp.rate_error !== w.err) report_mismatch("error", rsp.rate_error, w.err);
        if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
      end
    end
  end

  // directed table, reset configuration (14.7456 MHz, auto prescaler)
  dir_row_t dir_tab[] = '{
    '{23'd0,       1'b1, '{16'hFFFF, 3'd4, 27'd4, 27'd4, ST_OVERFLOW}},
    '{23'd1,       1'b1, '{16'hFFFF, 3'd4, 27'd4, 27'd3, ST_OVERFLOW}},
    '{23'd9600,    1'b1, '{16'd96, 3'd1, 27'd9600, 27'd0, ST_OK}},
    '{23'd115200,  1'b1, '{16'd8, 3'd1, 27'd115200, 27'd0, ST_OK}},
    '{23'd921600,  1'b1, '{16'd1, 3'd1, 27'd921600, 27'd0, ST_OK}},
    '{23'd5000000, 1'b1, '{16'd0, 3'd1, 27'd0, 27'd5000000, ST_ZERO}},
    '{23'h7FFFFF,  1'b1, '{16'd0, 3'd1, 27'd0, 27'h7FFFFF, ST_ZERO}},
    '{23'd300,     1'b0, '0},
    '{23'd14,      1'b0, '0},
    '{23'd2400,    1'b0, '0},
    '{23'd250000,  1'b0, '0},
    '{23'd1843200, 1'b0, '0},
    '{23'h555555,  1'b0, '0},
    '{23'h2AAAAA,  1'b0, '0}
  };

  // configurations walked by the random part: extremes included
  logic [FreqW-1:0] clk_set[] = '{27'd80_000_000, 27'd1, 27'd0, 27'h7FFFFFF,
                                  27'd1_843_200, 27'd48_000_000};
  logic [PreW-1:0]  pre_set[] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd0};

  initial begin
    div_res_t none;
    none = '0;
    n_errors = 0; n_results = 0; n_zero = 0; n_ovf = 0; n_four = 0;
    rx_hold = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_CLOCK_FREQ; cfg_data_i = '0;
    req.valid = 1'b0; req.desired_baud = '0;
    ref_clk_hz = 27'd14_745_600; ref_pre_sel = PRE_AUTO;
    rst_ni = 1'b0;
    wait_cycles(4);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_baud(dir_tab[i].baud, dir_tab[i].chk, dir_tab[i].res);
    drain();

    // each phase: new setting, then random requests
    foreach (clk_set[k]) begin
      write_reg(CFG_CLOCK_FREQ, clk_set[k]);
      write_reg(CFG_FORCED_PRE, FreqW'(pre_set[k]));
      if (k == 1) rx_hold = 1'b1;
      for (int i = 0; i < 65; i++) begin
        if (k == 1) begin
          // back-to-back burst against the stalled receiver
          req.valid <= 1'b1;
          req.desired_baud <= rand_baud();
          do @(posedge clk_i); while (!req.ready);
          expected_q.push_back(predict_divisor(req.desired_baud));
        end else begin
          send_baud(rand_baud(), 1'b0, none);
        end
      end
      drain();
    end

    $display("covered %0d results over %0d clock settings", n_results, clk_set.size());
    $display("  %0d rounded to zero, %0d overflowed, %0d on prescaler 4",
             n_zero, n_ovf, n_four);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ubd_pkg.sv
src/ubd_ifs.sv
src/ubd_div_pipe.sv
src/ubd_cand.sv
src/uart_baud_divisor_calculator.sv
test/tb_uart_baud_divisor_calculator.sv
